>>> rtl/core/sample_trigger_timebase_defines.svh
// Assertion macros for the port-level checker of the sample trigger timebase.
`ifndef SAMPLE_TRIGGER_TIMEBASE_DEFINES_SVH
`define SAMPLE_TRIGGER_TIMEBASE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/stt_pkg.sv
// Types and constants of the sample trigger timebase.
package stt_pkg;

    localparam int unsigned TICKS_PER_SECOND_DEF = 1024;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_ENABLE    = 2'd1,
        CMD_DISABLE   = 2'd2,
        CMD_LOAD_TIME = 2'd3
    } stt_cmd_t;

    typedef struct packed {
        stt_cmd_t    cmd;
        logic [31:0] time_value;
    } stt_item_t;

    typedef struct packed {
        logic        trigger_pulse;
        logic        timestamp_valid;
        logic [31:0] seconds_now;
        logic        trigger_on;
    } stt_result_t;

endpackage

>>> rtl/core/stt_in_stage.sv
// Input register of the sample trigger timebase: holds one accepted item.
module stt_in_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [stt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             advance,
    output logic                             item_valid,
    output stt_pkg::stt_item_t               item
);

    logic               valid_reg;
    logic               valid_next;
    stt_pkg::stt_item_t item_reg;

    // The register frees up when its item moves on in the same cycle.
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.cmd        <= stt_pkg::stt_cmd_t'(s_tdata[1:0]);
            item_reg.time_value <= s_tdata[33:2];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/core/stt_timebase.sv
// Counters, trigger state and configuration registers of the timebase.
module stt_timebase #(
    parameter int unsigned TICKS_PER_SECOND = stt_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [stt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [stt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             step,
    input  stt_pkg::stt_item_t               item,
    output stt_pkg::stt_result_t             result
);

    localparam int unsigned SUB_W = $clog2(TICKS_PER_SECOND);
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

    logic [15:0]      sample_period_reg;
    logic [31:0]      trigger_limit_reg;
    logic [31:0]      seconds_reg;
    logic [31:0]      seconds_next;
    logic [SUB_W-1:0] subsec_reg;
    logic [SUB_W-1:0] subsec_next;
    logic [15:0]      sample_reg;
    logic [15:0]      sample_next;
    logic [31:0]      pulses_reg;
    logic [31:0]      pulses_next;
    logic             active_reg;
    logic             active_next;

    logic [15:0]      sample_inc;
    logic [31:0]      pulses_inc;
    logic             pulse;
    logic             stamp;

    always_comb begin
        seconds_next = seconds_reg;
        subsec_next  = subsec_reg;
        sample_next  = sample_reg;
        pulses_next  = pulses_reg;
        active_next  = active_reg;
        pulse        = 1'b0;
        stamp        = 1'b0;
        sample_inc   = sample_reg + 16'd1;
        pulses_inc   = pulses_reg + 32'd1;
        case (item.cmd)
            stt_pkg::CMD_TICK: begin
                if (active_reg) begin
                    if (sample_inc == sample_period_reg) begin
                        pulse       = 1'b1;
                        pulses_next = pulses_inc;
                        sample_next = 16'd0;
                        if (pulses_inc == trigger_limit_reg) begin
                            active_next = 1'b0;
                        end
                    end else begin
                        sample_next = sample_inc;
                    end
                end
                if (subsec_reg == SUB_LAST) begin
                    subsec_next  = '0;
                    seconds_next = seconds_reg + 32'd1;
                    // A limit reached on this same tick suppresses the timestamp.
                    stamp        = active_next;
                end else begin
                    subsec_next  = subsec_reg + SUB_W'(1);
                end
            end
            stt_pkg::CMD_ENABLE: begin
                active_next = 1'b1;
                pulses_next = 32'd0;
                sample_next = 16'd0;
            end
            stt_pkg::CMD_DISABLE: begin
                active_next = 1'b0;
            end
            stt_pkg::CMD_LOAD_TIME: begin
                seconds_next = item.time_value;
                subsec_next  = '0;
                sample_next  = 16'd0;
            end
            default: begin
                active_next = active_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_period_reg <= 16'd0;
            trigger_limit_reg <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                stt_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= cfg_wdata[15:0];
                stt_pkg::REG_TRIGGER_LIMIT: trigger_limit_reg <= cfg_wdata[31:0];
                default: sample_period_reg <= sample_period_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seconds_reg <= 32'd0;
            subsec_reg  <= '0;
            sample_reg  <= 16'd0;
            pulses_reg  <= 32'd0;
            active_reg  <= 1'b0;
        end else if (step) begin
            seconds_reg <= seconds_next;
            subsec_reg  <= subsec_next;
            sample_reg  <= sample_next;
            pulses_reg  <= pulses_next;
            active_reg  <= active_next;
        end
    end

    assign result.trigger_pulse   = pulse;
    assign result.timestamp_valid = stamp;
    assign result.seconds_now     = seconds_next;
    assign result.trigger_on      = active_next;

endmodule

>>> rtl/core/stt_out_stage.sv
// Result register of the sample trigger timebase.
module stt_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             item_valid,
    input  stt_pkg::stt_result_t             result,
    output logic                             advance,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [stt_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic                 valid_reg;
    logic                 valid_next;
    stt_pkg::stt_result_t result_reg;
    logic                 room;

    assign room       = !valid_reg || m_tready;
    assign advance    = room && item_valid;
    assign valid_next = room ? item_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, result_reg.trigger_on, result_reg.seconds_now,
                       result_reg.timestamp_valid, result_reg.trigger_pulse};

endmodule

>>> rtl/core/sample_trigger_timebase.sv
// Top level of the sample trigger timebase.
//
//  channel   direction  contents
//  s_        in         one command item: tick, enable, disable or load time
//  m_        out        one result item for every command item
//  cfg_      in         register writes: sample period, trigger limit
//
// One item a cycle while m_tready allows; items pass the input and result registers.
// All counters advance as an item moves from the input register to the result register.
// Reset is synchronous and active low; it clears counters, registers and both stages.
// A stalled result holds the result register; one more item may wait in the input register.
module sample_trigger_timebase #(
    parameter int unsigned TICKS_PER_SECOND = stt_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] cmd, [33:2] time_value, [39:34] zero
    input  logic [stt_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] trigger_pulse, [1] timestamp_valid, [33:2] seconds_now, [34] trigger_on,
    // [39:35] zero
    output logic [stt_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_we,
    input  logic [stt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [stt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic                 advance;
    logic                 item_valid;
    stt_pkg::stt_item_t   item;
    stt_pkg::stt_result_t result;

    stt_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    stt_timebase #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_timebase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (item),
        .result    (result)
    );

    stt_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

>>> rtl/core/stt_checker.sv
// Port-level checker of the sample trigger timebase, bound to the top level.
`include "sample_trigger_timebase_defines.svh"

module stt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic [stt_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready
);

    // A stalled result item keeps its contents.
    `STT_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // A timestamp is only flagged while the trigger stays enabled.
    `STT_ASSERT_NOW(a_stamp_on, aclk, aresetn,
        m_tvalid && m_tdata[1], m_tdata[34], "timestamp without trigger enabled")

    // With no result pending the input side always has room.
    `STT_ASSERT_NOW(a_ready_free, aclk, aresetn,
        !m_tvalid, s_tready, "input stalled with empty output")

    // The first cycle after reset shows no result.
    `STT_ASSERT_NOW(a_reset_empty, aclk, aresetn,
        $rose(aresetn), !m_tvalid, "result present after reset")

endmodule

bind sample_trigger_timebase stt_checker u_stt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

>>> dv/tb_sample_trigger_timebase.sv
// Self-checking testbench for the sample trigger timebase: command stream in, results checked.
module tb_sample_trigger_timebase;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEMS_PER_PHASE = 130;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned STALL_LIMIT     = 5000;

    // Keeps its own copy of the timebase state and the queue of results still owed.
    class timebase_scoreboard;
        logic [15:0]          period;
        logic [31:0]          limit;
        logic [31:0]          secs;
        int unsigned          sub_ticks;
        bit   [15:0]          smp_ticks;
        logic [31:0]          pulse_count;
        bit                   trig_en;
        stt_pkg::stt_result_t pending[$];
        int unsigned          errors;

        function new();
            period      = '0;
            limit       = '0;
            secs        = '0;
            sub_ticks   = 0;
            smp_ticks   = '0;
            pulse_count = '0;
            trig_en     = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [stt_pkg::CFG_ADDR_W-1:0] idx,
                                logic [stt_pkg::CFG_DATA_W-1:0] value);
            if (idx == stt_pkg::REG_SAMPLE_PERIOD) begin
                period = value[15:0];
            end else begin
                limit = value;
            end
        endfunction

        function void take_command(stt_pkg::stt_cmd_t cmd, logic [31:0] tval);
            stt_pkg::stt_result_t want;
            want = '0;
            case (cmd)
                stt_pkg::CMD_TICK: begin
                    sub_ticks++;
                    if (trig_en) begin
                        smp_ticks++;
                        if (smp_ticks == period) begin
                            want.trigger_pulse = 1'b1;
                            pulse_count++;
                            if (pulse_count == limit) begin
                                trig_en = 1'b0;
                            end
                            smp_ticks = '0;
                        end
                    end
                    // A limit reached on this same tick has already cleared the enable.
                    if (sub_ticks >= stt_pkg::TICKS_PER_SECOND_DEF) begin
                        secs++;
                        if (trig_en) begin
                            want.timestamp_valid = 1'b1;
                        end
                        sub_ticks = 0;
                    end
                end
                stt_pkg::CMD_ENABLE: begin
                    trig_en     = 1'b1;
                    pulse_count = '0;
                    smp_ticks   = '0;
                end
                stt_pkg::CMD_DISABLE: begin
                    trig_en = 1'b0;
                end
                default: begin
                    secs      = tval;
                    sub_ticks = 0;
                    smp_ticks = '0;
                end
            endcase
            want.seconds_now = secs;
            want.trigger_on  = trig_en;
            pending.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [stt_pkg::M_TDATA_W-1:0] data);
            stt_pkg::stt_result_t want;
            if (pending.size() == 0) begin
                $error("result %h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("trigger_pulse", 32'(want.trigger_pulse), 32'(data[0]));
            compare_field("timestamp_valid", 32'(want.timestamp_valid), 32'(data[1]));
            compare_field("seconds_now", want.seconds_now, data[33:2]);
            compare_field("trigger_on", 32'(want.trigger_on), 32'(data[34]));
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    // [1:0] cmd, [33:2] time_value, [39:34] zero
    logic [stt_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    // [0] trigger_pulse, [1] timestamp_valid, [33:2] seconds_now, [34] trigger_on,
    // [39:35] zero
    logic [stt_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            cfg_we;
    logic [stt_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [stt_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    bit                     steady;
    logic [15:0]            phase_period [RANDOM_PHASES];
    logic [31:0]            phase_limit  [RANDOM_PHASES];

    timebase_scoreboard board = new();

    sample_trigger_timebase u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic send_command(stt_pkg::stt_cmd_t cmd, logic [31:0] tval);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 27) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, tval, cmd};
        do @(posedge aclk); while (!s_tready);
        board.take_command(cmd, tval);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(logic [stt_pkg::CFG_ADDR_W-1:0] idx,
                                  logic [stt_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        board.write_reg(idx, value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Result side: random back-pressure unless steady, results checked on the rising edge.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = steady || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("sample_trigger_timebase regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned       roll;
        stt_pkg::stt_cmd_t cmd;
        logic [31:0]       tval;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        steady    = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Short directed run: a pulse every second tick, self-disable after three pulses.
        write_register(stt_pkg::REG_SAMPLE_PERIOD, 32'd2);
        write_register(stt_pkg::REG_TRIGGER_LIMIT, 32'd3);
        send_command(stt_pkg::CMD_TICK, 32'hFFFF_FFFF);
        send_command(stt_pkg::CMD_DISABLE, 32'h0);
        send_command(stt_pkg::CMD_ENABLE, 32'h0);
        repeat (7) send_command(stt_pkg::CMD_TICK, 32'h0);
        send_command(stt_pkg::CMD_ENABLE, 32'h1234_5678);
        send_command(stt_pkg::CMD_DISABLE, 32'h0);
        send_command(stt_pkg::CMD_TICK, 32'h0);
        send_command(stt_pkg::CMD_LOAD_TIME, 32'hFFFF_FFFF);
        send_command(stt_pkg::CMD_LOAD_TIME, 32'h0);
        send_command(stt_pkg::CMD_TICK, 32'h0);
        send_command(stt_pkg::CMD_ENABLE, 32'h0);
        send_command(stt_pkg::CMD_LOAD_TIME, 32'h5A5A_A5A5);
        send_command(stt_pkg::CMD_TICK, 32'h0);
        send_command(stt_pkg::CMD_TICK, 32'h0);
        send_command(stt_pkg::CMD_DISABLE, 32'h0);
        wait_for_results();

        phase_period[0] = 16'd1;     phase_limit[0] = 32'd0;
        phase_period[1] = 16'd3;     phase_limit[1] = 32'd4;
        phase_period[2] = 16'hFFFF;  phase_limit[2] = 32'hFFFF_FFFF;
        phase_period[3] = 16'd0;     phase_limit[3] = 32'd0;
        phase_period[4] = 16'($urandom_range(12, 1));
        phase_limit[4]  = $urandom_range(6, 1);
        phase_period[5] = 16'd2;     phase_limit[5] = 32'd1;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_for_results();
            write_register(stt_pkg::REG_SAMPLE_PERIOD, 32'(phase_period[p]));
            write_register(stt_pkg::REG_TRIGGER_LIMIT, phase_limit[p]);
            steady = (p == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Let the pipeline run dry once in the middle of a phase.
                if (p == 2 && n == 60) begin
                    wait_for_results();
                end
                roll = $urandom_range(99);
                if (roll < 82) begin
                    cmd = stt_pkg::CMD_TICK;
                end else if (roll < 88) begin
                    cmd = stt_pkg::CMD_ENABLE;
                end else if (roll < 93) begin
                    cmd = stt_pkg::CMD_DISABLE;
                end else begin
                    cmd = stt_pkg::CMD_LOAD_TIME;
                end
                roll = $urandom_range(9);
                if (roll == 0) begin
                    tval = 32'h0;
                end else if (roll == 1) begin
                    tval = 32'hFFFF_FFFF;
                end else begin
                    tval = $urandom;
                end
                send_command(cmd, tval);
            end
        end
        steady = 1'b0;

        wait_for_results();
        repeat (4) @(posedge aclk);
        if (board.errors == 0) begin
            $display("sample_trigger_timebase regression: pass");
        end else begin
            $display("sample_trigger_timebase regression: fail");
        end
        $finish;
    end

endmodule
